### hdl/rte_pkg.sv
// shared types, constants and angle table for the zyx euler angle core
package rte_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 18;
    localparam int OUT_W     = 19;
    localparam int CFG_W     = 17;
    localparam int GUARD     = 20;
    // cordic operand width: one bit more than an input so that a negation fits
    localparam int AW        = IN_W + 1;
    localparam int XW        = AW + GUARD + 3;
    localparam int ZW        = 36;
    localparam int SH        = 30 - FRAC_BITS;
    // square root: 33-bit radicand, one result bit per stage
    localparam int RAD_W     = 2 * FRAC_BITS + 1;
    localparam int ROOT_W    = FRAC_BITS + 2;
    localparam int SQ_STEPS  = FRAC_BITS + 1;
    localparam int SQ_W      = 2 * AW;

    localparam logic signed [ZW-1:0]    PI_Q30 = 36'sd3373259426;
    localparam logic signed [OUT_W-1:0] PI_F   = 19'sd205887;
    localparam logic signed [OUT_W-1:0] HP_F   = 19'sd102944;
    localparam logic [CFG_W-1:0]        THRESH_RESET = 17'd65535;

    // operands that travel beside the square root
    typedef struct packed {
        logic signed [AW-1:0]   sine;
        logic signed [IN_W-1:0] yaw_y;
        logic signed [IN_W-1:0] yaw_x;
        logic signed [IN_W-1:0] roll_y;
        logic signed [IN_W-1:0] roll_x;
        logic                   locked;
        logic                   pos;
    } side_t;

    // branch flags that travel beside the cordic units
    typedef struct packed {
        logic locked;
        logic pos;
    } flags_t;

    // atan(2^-k) in q30, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_q30(input int unsigned k);
        logic signed [ZW-1:0] a;
        unique case (k)
            0:  a = 36'sd843314857;
            1:  a = 36'sd497837829;
            2:  a = 36'sd263043837;
            3:  a = 36'sd133525159;
            4:  a = 36'sd67021687;
            5:  a = 36'sd33543516;
            6:  a = 36'sd16775851;
            7:  a = 36'sd8388437;
            8:  a = 36'sd4194283;
            9:  a = 36'sd2097149;
            default:
            begin
                if (k < 31)
                    a = ZW'(64'sd1 <<< (30 - k));
                else
                    a = '0;
            end
        endcase
        return a;
    endfunction

endpackage

### hdl/rte_isqrt.sv
// pipelined integer square root, one result bit per stage
module rte_isqrt
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [rte_pkg::RAD_W-1:0]   radicand,
    output logic [rte_pkg::ROOT_W-1:0]  root
);

    localparam int N  = rte_pkg::SQ_STEPS;
    localparam int RW = rte_pkg::RAD_W + 1;

    logic [RW-1:0] rem_reg [1:N];
    logic [RW-1:0] r_reg   [1:N];

    genvar j;
    generate
        for (j = 0; j < N; j++)
        begin : g_step
            localparam logic [RW-1:0] BIT = RW'(1) << (2 * (N - 1 - j));
            logic [RW-1:0] rem_cur;
            logic [RW-1:0] r_cur;
            logic [RW-1:0] trial;

            if (j == 0)
            begin : g_first
                assign rem_cur = {1'b0, radicand};
                assign r_cur   = '0;
            end
            else
            begin : g_next
                assign rem_cur = rem_reg[j];
                assign r_cur   = r_reg[j];
            end

            assign trial = r_cur + BIT;

            // restoring step: try this root bit
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (rem_cur >= trial)
                    begin
                        rem_reg[j+1] <= rem_cur - trial;
                        r_reg[j+1]   <= (r_cur >> 1) + BIT;
                    end
                    else
                    begin
                        rem_reg[j+1] <= rem_cur;
                        r_reg[j+1]   <= r_cur >> 1;
                    end
                end
            end
        end
    endgenerate

    assign root = r_reg[N][rte_pkg::ROOT_W-1:0];

endmodule

### hdl/rte_cordic.sv
// pipelined vectoring cordic atan2 with rounding and clamp to +-pi
module rte_cordic
#(
    parameter int STAGES = 18
)
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [rte_pkg::AW-1:0]     y_in,
    input  logic signed [rte_pkg::AW-1:0]     x_in,
    output logic signed [rte_pkg::OUT_W-1:0]  angle
);

    localparam int XW = rte_pkg::XW;
    localparam int ZW = rte_pkg::ZW;

    logic signed [XW-1:0] x_reg [0:STAGES];
    logic signed [XW-1:0] y_reg [0:STAGES];
    logic signed [ZW-1:0] z_reg [0:STAGES];
    logic signed [rte_pkg::OUT_W-1:0] angle_reg;

    logic signed [XW-1:0] x_ext;
    logic signed [XW-1:0] y_ext;

    assign x_ext = XW'(x_in) <<< rte_pkg::GUARD;
    assign y_ext = XW'(y_in) <<< rte_pkg::GUARD;

    // left half plane folds over by pi
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (x_in < 0)
            begin
                x_reg[0] <= -x_ext;
                y_reg[0] <= -y_ext;
                z_reg[0] <= (y_in >= 0) ? rte_pkg::PI_Q30 : -rte_pkg::PI_Q30;
            end
            else
            begin
                x_reg[0] <= x_ext;
                y_reg[0] <= y_ext;
                z_reg[0] <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < STAGES; i++)
        begin : g_stage
            localparam logic signed [ZW-1:0] ATAN = rte_pkg::atan_q30(i);
            logic signed [XW-1:0] xs;
            logic signed [XW-1:0] ys;

            assign xs = x_reg[i] >>> i;
            assign ys = y_reg[i] >>> i;

            // rotate toward the x axis
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (y_reg[i] > 0)
                    begin
                        x_reg[i+1] <= x_reg[i] + ys;
                        y_reg[i+1] <= y_reg[i] - xs;
                        z_reg[i+1] <= z_reg[i] + ATAN;
                    end
                    else if (y_reg[i] < 0)
                    begin
                        x_reg[i+1] <= x_reg[i] - ys;
                        y_reg[i+1] <= y_reg[i] + xs;
                        z_reg[i+1] <= z_reg[i] - ATAN;
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i];
                        y_reg[i+1] <= y_reg[i];
                        z_reg[i+1] <= z_reg[i];
                    end
                end
            end
        end
    endgenerate

    // round q30 to the output format and clamp
    logic signed [ZW-1:0] z_rnd;
    logic signed [ZW-1:0] pi_ext;

    assign z_rnd  = (z_reg[STAGES] + (ZW'(1) <<< (rte_pkg::SH - 1))) >>> rte_pkg::SH;
    assign pi_ext = ZW'(rte_pkg::PI_F);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (z_rnd > pi_ext)
                angle_reg <= rte_pkg::PI_F;
            else if (z_rnd < -pi_ext)
                angle_reg <= -rte_pkg::PI_F;
            else
                angle_reg <= z_rnd[rte_pkg::OUT_W-1:0];
        end
    end

    assign angle = angle_reg;

endmodule

### hdl/rotation_to_euler_zyx_core.sv
// zyx euler angle extraction from a rotation matrix, top level
// throughput: one word per cycle; the whole pipeline advances unless a held output is stalled
// the 17-stage square root and the three parallel cordic pipelines set the depth
// reset: valid bits cleared, gimbal threshold set to 65535; payload registers are not reset
module rotation_to_euler_zyx_core
#(
    parameter int CORDIC_STAGES = 18
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [rte_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [rte_pkg::IN_W-1:0]     m00,
    input  logic signed [rte_pkg::IN_W-1:0]     m01,
    input  logic signed [rte_pkg::IN_W-1:0]     m10,
    input  logic signed [rte_pkg::IN_W-1:0]     m11,
    input  logic signed [rte_pkg::IN_W-1:0]     m20,
    input  logic signed [rte_pkg::IN_W-1:0]     m21,
    input  logic signed [rte_pkg::IN_W-1:0]     m22,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [rte_pkg::OUT_W-1:0]    pitch_angle,
    output logic signed [rte_pkg::OUT_W-1:0]    roll_angle,
    output logic signed [rte_pkg::OUT_W-1:0]    yaw_angle,
    output logic                                gimbal_locked
);

    localparam int AW   = rte_pkg::AW;
    localparam int NSQ  = rte_pkg::SQ_STEPS;
    localparam int NFL  = CORDIC_STAGES + 2;
    localparam int LAT  = 2 + NSQ + NFL + 1;

    logic en;
    logic [rte_pkg::CFG_W-1:0] thresh_reg;
    logic [LAT-1:0] vld_reg;

    // advance unless the output word is held
    assign en       = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !en;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= rte_pkg::THRESH_RESET;
        else if (cfg_wr_en)
            thresh_reg <= cfg_wr_data;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // stage a: pitch sine, its square, lock decision and yaw operand choice
    logic signed [AW-1:0] s_cur;
    logic [AW-1:0]        mag_cur;
    logic [rte_pkg::SQ_W-1:0] sq_reg;
    rte_pkg::side_t       side_a_reg;
    rte_pkg::side_t       side_a_next;

    assign s_cur   = -AW'(m20);
    assign mag_cur = s_cur[AW-1] ? AW'(-s_cur) : AW'(s_cur);

    always_comb
    begin
        side_a_next.sine   = s_cur;
        side_a_next.locked = mag_cur > AW'(thresh_reg);
        side_a_next.pos    = !s_cur[AW-1] && (s_cur != '0);
        side_a_next.roll_y = m21;
        side_a_next.roll_x = m22;
        side_a_next.yaw_y  = side_a_next.locked ? m01 : m10;
        side_a_next.yaw_x  = side_a_next.locked ? m11 : m00;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg     <= rte_pkg::SQ_W'(s_cur * s_cur);
            side_a_reg <= side_a_next;
        end
    end

    // stage b: cosine squared, floored at zero
    localparam logic [rte_pkg::SQ_W-1:0] ONE2 = rte_pkg::SQ_W'(1) << (2 * rte_pkg::FRAC_BITS);
    logic [rte_pkg::RAD_W-1:0] c2_reg;
    rte_pkg::side_t side_dly_reg [0:NSQ];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_reg <= (sq_reg >= ONE2) ? '0 : rte_pkg::RAD_W'(ONE2 - sq_reg);
            side_dly_reg[0] <= side_a_reg;
        end
    end

    // square root, operands delayed alongside
    logic [rte_pkg::ROOT_W-1:0] root;

    rte_isqrt u_isqrt
    (
        .clk      (clk),
        .en       (en),
        .radicand (c2_reg),
        .root     (root)
    );

    genvar k;
    generate
        for (k = 0; k < NSQ; k++)
        begin : g_side
            always_ff @(posedge clk)
            begin
                if (en)
                    side_dly_reg[k+1] <= side_dly_reg[k];
            end
        end
    endgenerate

    rte_pkg::side_t side_c;
    assign side_c = side_dly_reg[NSQ];

    // three atan2 pipelines
    logic signed [rte_pkg::OUT_W-1:0] pitch_a;
    logic signed [rte_pkg::OUT_W-1:0] roll_a;
    logic signed [rte_pkg::OUT_W-1:0] yaw_a;

    rte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch
    (
        .clk   (clk),
        .en    (en),
        .y_in  (side_c.sine),
        .x_in  ({1'b0, root}),
        .angle (pitch_a)
    );

    rte_cordic #(.STAGES(CORDIC_STAGES)) u_roll
    (
        .clk   (clk),
        .en    (en),
        .y_in  (AW'(side_c.roll_y)),
        .x_in  (AW'(side_c.roll_x)),
        .angle (roll_a)
    );

    rte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw
    (
        .clk   (clk),
        .en    (en),
        .y_in  (AW'(side_c.yaw_y)),
        .x_in  (AW'(side_c.yaw_x)),
        .angle (yaw_a)
    );

    // branch flags delayed over the cordic depth
    rte_pkg::flags_t fl_reg [0:NFL-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fl_reg[0].locked <= side_c.locked;
            fl_reg[0].pos    <= side_c.pos;
        end
    end

    generate
        for (k = 1; k < NFL; k++)
        begin : g_flags
            always_ff @(posedge clk)
            begin
                if (en)
                    fl_reg[k] <= fl_reg[k-1];
            end
        end
    endgenerate

    // output word: lock branch selection
    logic signed [rte_pkg::OUT_W-1:0] pitch_reg;
    logic signed [rte_pkg::OUT_W-1:0] roll_reg;
    logic signed [rte_pkg::OUT_W-1:0] yaw_reg;
    logic                             locked_reg;
    rte_pkg::flags_t                  fl_o;

    assign fl_o = fl_reg[NFL-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            locked_reg <= fl_o.locked;
            if (fl_o.locked)
            begin
                pitch_reg <= fl_o.pos ? rte_pkg::HP_F : -rte_pkg::HP_F;
                roll_reg  <= '0;
                yaw_reg   <= -yaw_a;
            end
            else
            begin
                pitch_reg <= pitch_a;
                roll_reg  <= roll_a;
                yaw_reg   <= yaw_a;
            end
        end
    end

    assign out_valid     = vld_reg[LAT-1];
    assign pitch_angle   = pitch_reg;
    assign roll_angle    = roll_reg;
    assign yaw_angle     = yaw_reg;
    assign gimbal_locked = locked_reg;

    // checks
    a_stall_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow held output");

    a_locked_roll_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gimbal_locked |-> roll_angle == '0)
        else $error("roll not zero in lock branch");

    a_locked_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gimbal_locked |->
            (pitch_angle == rte_pkg::HP_F || pitch_angle == -rte_pkg::HP_F))
        else $error("pitch not at half pi in lock branch");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pitch_angle <= rte_pkg::PI_F && pitch_angle >= -rte_pkg::PI_F
                       && roll_angle <= rte_pkg::PI_F && roll_angle >= -rte_pkg::PI_F))
        else $error("angle out of range");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(yaw_angle))
        else $error("held output word changed");

endmodule
